// ----- sv/tkst_pkg.sv -----
// shared types, constants and helper functions of the key sequence tokenizer
package tkst_pkg;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CSI   = 8'h5B;
    localparam logic [7:0] CH_SS3   = 8'h4F;
    localparam logic [7:0] CH_CYR0  = 8'hD0;
    localparam logic [7:0] CH_CYR1  = 8'hD1;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CFG_LIMIT   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam int          LEN_W     = 5;
    localparam int          TMO_W     = 20;
    localparam int          LEN_MAX   = 31;
    localparam logic [19:0] WAIT_MAX  = 20'hFFFFF;
    localparam int          QDEPTH    = 4;
    localparam int          QAW       = 2;

    typedef enum logic [2:0] {
        K_UTF8     = 3'd0,
        K_LONE_ESC = 3'd1,
        K_CSI      = 3'd2,
        K_ESC_BYTE = 3'd3,
        K_ESC_CYR  = 3'd4,
        K_CUT      = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [LEN_W-1:0]  length;
    } t_desc;

    typedef enum logic {
        B_IDLE = 1'b0,
        B_WAIT = 1'b1
    } t_back_state;

    function automatic logic [2:0] utf8_need(input logic [7:0] lead);
        logic [2:0] n;
        if (lead < 8'h80) begin
            n = 3'd1;
        end else if (lead >= 8'hC0 && lead <= 8'hDF) begin
            n = 3'd2;
        end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
            n = 3'd3;
        end else if (lead >= 8'hF0 && lead <= 8'hF7) begin
            n = 3'd4;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

endpackage

// ----- sv/tkst_ram.sv -----
// generic simple dual port ram with registered read
module tkst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tkst_front.sv -----
// front end: accepts bytes and ticks, buffers token bytes and decides where tokens end
module tkst_front import tkst_pkg::*; #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [TMO_W-1:0]               i_cfg_wdata,
    input  logic                           i_push,
    input  logic                           i_op,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_full,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output t_desc                          o_q_desc,
    output logic                           o_ram_we,
    output logic [$clog2(2*BUF_DEPTH)-1:0] o_ram_waddr,
    output logic [7:0]                     o_ram_wdata,
    input  logic                           i_byte_done
);

    localparam int RING = 2 * BUF_DEPTH;
    localparam int AW   = $clog2(RING);
    localparam int UW   = $clog2(RING + 1);
    localparam int CAPI = (BUF_DEPTH < LEN_MAX) ? BUF_DEPTH : LEN_MAX;
    localparam logic [LEN_W-1:0] CAP = LEN_W'(CAPI);

    logic [LEN_W-1:0] r_limit, n_limit;
    logic [TMO_W-1:0] r_tmo, n_tmo;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic [7:0]       r_first, n_first;
    logic [7:0]       r_second, n_second;
    logic [TMO_W-1:0] r_wait, n_wait;
    logic [AW-1:0]    r_base, n_base;
    logic [AW-1:0]    r_wr, n_wr;
    logic [UW-1:0]    r_used, n_used;

    logic             accept, is_byte, is_tick;
    logic [LEN_W-1:0] lim_eff;
    logic [TMO_W-1:0] tmo_eff;
    logic             discard;
    logic [LEN_W-1:0] fill_base, len;
    logic [7:0]       first_b, second_b;
    logic [AW-1:0]    waddr, wr_next;
    logic             byte_emit;
    t_kind            byte_kind;
    logic             lone, tick_emit;
    logic [TMO_W-1:0] wait_inc;

    assign o_full  = (r_used == UW'(RING)) || i_q_full;
    assign accept  = i_push && !o_full;
    assign is_byte = accept && (i_op == OP_BYTE);
    assign is_tick = accept && (i_op == OP_TICK);

    always_comb begin
        lim_eff = (r_limit == '0) ? LEN_W'(1) : r_limit;
        if (lim_eff > CAP) begin
            lim_eff = CAP;
        end
        tmo_eff = (r_tmo == '0) ? TMO_W'(1) : r_tmo;
    end

    assign discard   = (r_fill >= lim_eff);
    assign fill_base = discard ? '0 : r_fill;
    assign len       = fill_base + LEN_W'(1);
    assign first_b   = (fill_base == '0) ? i_data_byte : r_first;
    assign second_b  = (fill_base == LEN_W'(1)) ? i_data_byte : r_second;
    assign waddr     = discard ? r_base : r_wr;
    assign wr_next   = (waddr == AW'(RING - 1)) ? '0 : waddr + AW'(1);

    // token end rules for a received byte
    always_comb begin
        byte_emit = 1'b0;
        byte_kind = K_UTF8;
        if (first_b == CH_ESC) begin
            if (len >= LEN_W'(2)) begin
                if (second_b == CH_CSI || second_b == CH_SS3) begin
                    if (len > LEN_W'(2) && (is_letter(i_data_byte) || i_data_byte == CH_TILDE))
                    begin
                        byte_emit = 1'b1;
                        byte_kind = K_CSI;
                    end
                end else if (second_b == CH_CYR0 || second_b == CH_CYR1) begin
                    if (len > LEN_W'(2)) begin
                        byte_emit = 1'b1;
                        byte_kind = K_ESC_CYR;
                    end
                end else begin
                    byte_emit = 1'b1;
                    byte_kind = K_ESC_BYTE;
                end
            end
        end else if (len >= LEN_W'(utf8_need(first_b))) begin
            byte_emit = 1'b1;
            byte_kind = K_UTF8;
        end
        if (!byte_emit && len >= lim_eff) begin
            byte_emit = 1'b1;
            byte_kind = K_CUT;
        end
    end

    assign lone      = (r_fill == LEN_W'(1)) && (r_first == CH_ESC);
    assign wait_inc  = (r_wait == WAIT_MAX) ? r_wait : r_wait + TMO_W'(1);
    assign tick_emit = lone && (wait_inc >= tmo_eff);

    always_comb begin
        n_limit     = r_limit;
        n_tmo       = r_tmo;
        n_fill      = r_fill;
        n_first     = r_first;
        n_second    = r_second;
        n_wait      = r_wait;
        n_base      = r_base;
        n_wr        = r_wr;
        n_used      = r_used - (i_byte_done ? UW'(1) : UW'(0));
        o_q_push    = 1'b0;
        o_q_desc    = '{kind: K_UTF8, length: len};
        o_ram_we    = 1'b0;
        o_ram_waddr = waddr;
        o_ram_wdata = i_data_byte;
        if (i_cfg_we) begin
            if (i_cfg_addr == CFG_LIMIT) begin
                n_limit = i_cfg_wdata[LEN_W-1:0];
            end else begin
                n_tmo = i_cfg_wdata;
            end
        end
        if (is_byte) begin
            o_ram_we = 1'b1;
            n_first  = first_b;
            n_second = second_b;
            n_wr     = wr_next;
            n_used   = n_used + UW'(1) - (discard ? UW'(r_fill) : UW'(0));
            if (byte_emit) begin
                o_q_push = 1'b1;
                o_q_desc = '{kind: byte_kind, length: len};
                n_fill   = '0;
                n_base   = wr_next;
                n_wait   = '0;
            end else begin
                n_fill = len;
                if (fill_base == '0) begin
                    n_wait = '0;
                end
            end
        end else if (is_tick && lone) begin
            n_wait = wait_inc;
            if (tick_emit) begin
                o_q_push = 1'b1;
                o_q_desc = '{kind: K_LONE_ESC, length: LEN_W'(1)};
                n_fill   = '0;
                n_wait   = '0;
                n_base   = r_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LEN_W'(15);
            r_tmo   <= TMO_W'(100);
            r_fill  <= '0;
            r_wait  <= '0;
            r_base  <= '0;
            r_wr    <= '0;
            r_used  <= '0;
        end else begin
            r_limit <= n_limit;
            r_tmo   <= n_tmo;
            r_fill  <= n_fill;
            r_wait  <= n_wait;
            r_base  <= n_base;
            r_wr    <= n_wr;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
    end

    // ring never overfills
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_used <= UW'(RING))
        else $error("ring occupancy out of range");

    // a token never outgrows its limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_byte && !discard |-> len <= CAP)
        else $error("token longer than buffer");

endmodule

// ----- sv/tkst_queue.sv -----
// short queue of finished token descriptors between front and back end
module tkst_queue import tkst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (QAW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into full descriptor queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop from empty descriptor queue");

endmodule

// ----- sv/tkst_back.sv -----
// back end: reads finished tokens from the ring and hands out one byte per item
module tkst_back import tkst_pkg::*; #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  t_desc                          i_q_desc,
    output logic                           o_q_pop,
    output logic                           o_ram_re,
    output logic [$clog2(2*BUF_DEPTH)-1:0] o_ram_raddr,
    input  logic [7:0]                     i_ram_rdata,
    output logic                           o_byte_done,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [7:0]                     o_token_byte,
    output logic                           o_token_end,
    output logic [2:0]                     o_token_kind,
    output logic [LEN_W-1:0]               o_token_length
);

    localparam int RING = 2 * BUF_DEPTH;
    localparam int AW   = $clog2(RING);

    t_back_state      r_state, n_state;
    logic [AW-1:0]    r_rd, rd_inc;
    logic [LEN_W-1:0] r_pos;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_oend;
    t_kind            r_okind;
    logic [LEN_W-1:0] r_olen;

    logic can_load, last, load;

    assign can_load = !r_ovalid || i_pop;
    assign last     = (r_pos + LEN_W'(1) == i_q_desc.length);
    assign rd_inc   = (r_rd == AW'(RING - 1)) ? '0 : r_rd + AW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: n_state = i_q_valid ? B_WAIT : B_IDLE;
            B_WAIT: n_state = (can_load && last) ? B_IDLE : B_WAIT;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        load        = 1'b0;
        o_q_pop     = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rd;
        unique case (r_state)
            B_IDLE: begin
                o_ram_re = i_q_valid;
            end
            B_WAIT: begin
                load = can_load;
                if (can_load) begin
                    o_q_pop     = last;
                    o_ram_re    = !last;
                    o_ram_raddr = rd_inc;
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign o_byte_done = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rd     <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_rd     <= rd_inc;
                r_pos    <= last ? '0 : r_pos + LEN_W'(1);
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obyte <= i_ram_rdata;
            r_oend  <= last;
            r_okind <= i_q_desc.kind;
            r_olen  <= i_q_desc.length;
        end
    end

    assign o_empty        = !r_ovalid;
    assign o_token_byte   = r_obyte;
    assign o_token_end    = r_oend;
    assign o_token_kind   = r_okind;
    assign o_token_length = r_olen;

    // draining only happens against a descriptor at the queue head
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_WAIT |-> i_q_valid)
        else $error("draining without a token descriptor");

endmodule

// ----- sv/terminal_key_sequence_tokenizer_unit.sv -----
// top level of the key sequence tokenizer: front end, descriptor queue, ring ram, back end
// a token's descriptor passes through the descriptor queue; the back end then reads the ring ram
//   and registers each byte of the token at its output
// throughput: one input item per cycle while o_full is low; results drain at one byte per cycle,
//   set by the ring ram read port, while the consumer pops; each token first passes the idle state
//   that starts the read. input stalls when the byte ring (2 x BUF_DEPTH) or the 4 entry descriptor queue is full
// synchronous active low reset clears all control state; no clearing pass, ring contents undefined
module terminal_key_sequence_tokenizer_unit import tkst_pkg::*; #(
    parameter int BUF_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [TMO_W-1:0] i_cfg_wdata,
    input  logic             i_push,
    output logic             o_full,
    input  logic             i_op,
    input  logic [7:0]       i_data_byte,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_token_byte,
    output logic             o_token_end,
    output logic [2:0]       o_token_kind,
    output logic [LEN_W-1:0] o_token_length
);

    localparam int RING = 2 * BUF_DEPTH;
    localparam int AW   = $clog2(RING);

    logic          q_full, q_push, q_pop, q_valid;
    t_desc         q_in_desc, q_out_desc;
    logic          ram_we, ram_re, byte_done;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    tkst_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (i_push),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_full      (o_full),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_desc    (q_in_desc),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .i_byte_done (byte_done)
    );

    tkst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_out_desc)
    );

    tkst_ram #(.WIDTH(8), .DEPTH(RING)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tkst_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_desc       (q_out_desc),
        .o_q_pop        (q_pop),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_byte_done    (byte_done),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_token_byte   (o_token_byte),
        .o_token_end    (o_token_end),
        .o_token_kind   (o_token_kind),
        .o_token_length (o_token_length)
    );

endmodule
